// File: design/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and defaults for the LRU register cache with its fill queue.
// ----------------------------------------------------------------------------
package lrc_pkg;

    // default sizes
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_FILL_DEPTH = 16;
    localparam int DEF_AGE_BITS   = 16;
    localparam int DEF_ADDR_BITS  = 32;

    // fixed widths of the item fields
    localparam int IN_ADDR_BITS  = 32;
    localparam int OUT_ADDR_BITS = 32;
    localparam int OUT_IDX_BITS  = 4;

    // control part of the search token that walks down the cell row
    typedef struct packed {
        logic active;     // token present at this cell
        logic tick;       // 1 = aging / victim search, 0 = lookup
        logic found;      // lookup already matched an earlier cell
        logic vic_valid;  // current victim candidate is a valid entry
    } t_tok_ctl;

endpackage

// File: design/lru_register_cache_with_fill_queue.sv
// ----------------------------------------------------------------------------
// lru_register_cache_with_fill_queue
// Fully associative LRU address cache built as a row of entry cells, with a
// FIFO of pending fills that a tick installs into the victim entry.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  in       | i_valid / o_stall | i_mode, i_address
//  out      | o_valid / i_stall | o_hit, o_fill_overflow, o_installed,
//           |                   | o_installed_address, o_victim_index
//
//  One item at a time. A search token walks the cell row one cell per cycle.
//  A tick's result is ready once the token leaves the last cell; a lookup's
//  after that and a scan of the fill queue, which reads one slot per cycle.
//  No new item is taken until the result is registered.
//  A stalled result holds the item in its last step until the register frees.
//  Reset (synchronous, active low) empties the cache and the fill queue.
// ----------------------------------------------------------------------------
module lru_register_cache_with_fill_queue
    import lrc_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int FILL_DEPTH = DEF_FILL_DEPTH,
    parameter int AGE_BITS   = DEF_AGE_BITS,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input items
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_mode,
    input  logic [IN_ADDR_BITS-1:0]  i_address,
    // result items
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_hit,
    output logic                     o_fill_overflow,
    output logic                     o_installed,
    output logic [OUT_ADDR_BITS-1:0] o_installed_address,
    output logic [OUT_IDX_BITS-1:0]  o_victim_index
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int PTR_W = (FILL_DEPTH > 1) ? $clog2(FILL_DEPTH) : 1;
    localparam int CNT_W = $clog2(FILL_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FILL_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHAIN,
        S_QSCAN,
        S_FINISH
    } t_state;

    t_state               r_state;
    logic                 r_tick;
    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_found;
    logic [IDX_W-1:0]     r_vic_idx;
    logic [CNT_W-1:0]     r_qi;
    logic                 r_pend;

    logic                     r_out_valid;
    logic                     r_hit;
    logic                     r_ovf;
    logic                     r_inst;
    logic [OUT_ADDR_BITS-1:0] r_inst_addr;
    logic [OUT_IDX_BITS-1:0]  r_vic_out;

    logic                 w_accept;
    logic                 w_commit;
    logic [ADDR_BITS-1:0] w_addr_in;
    logic [ADDR_BITS-1:0] w_addr_bus;
    logic [ADDR_BITS+IN_ADDR_BITS-1:0]  w_addr_in_ext;
    logic [ADDR_BITS+OUT_ADDR_BITS-1:0] w_rd_ext;
    logic [IDX_W+OUT_IDX_BITS-1:0]      w_vic_ext;

    logic [PTR_W-1:0]     w_rd_offset;
    logic [ADDR_BITS-1:0] w_rd_data;
    logic [CNT_W-1:0]     w_count;
    logic                 w_q_full;
    logic                 w_q_nonempty;
    logic                 w_push;
    logic                 w_pop;

    t_tok_ctl             w_tok  [ENTRIES+1];
    logic [AGE_BITS-1:0]  w_vage [ENTRIES+1];
    logic [IDX_W-1:0]     w_vidx [ENTRIES+1];

    // address kept to ADDR_BITS, and back to the 32-bit result field
    assign w_addr_in_ext = {{ADDR_BITS{1'b0}}, i_address};
    assign w_addr_in     = w_addr_in_ext[ADDR_BITS-1:0];
    assign w_rd_ext      = {{OUT_ADDR_BITS{1'b0}}, w_rd_data};
    assign w_vic_ext     = {{OUT_IDX_BITS{1'b0}}, r_vic_idx};

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_addr_bus = w_accept ? w_addr_in : r_addr;

    // queue status and commit
    assign w_q_full     = (w_count == FULL_CNT);
    assign w_q_nonempty = (w_count != '0);
    assign w_commit     = (r_state == S_FINISH) && (!r_out_valid || !i_stall);
    assign w_push       = w_commit && !r_tick && !r_found && !w_q_full;
    assign w_pop        = w_commit && r_tick && w_q_nonempty;

    // scan reads relative slots; otherwise the head slot is read
    assign w_rd_offset = (r_state == S_QSCAN) ? r_qi[PTR_W-1:0] : '0;

    // token injected into the first cell on accept
    always_comb begin
        w_tok[0].active    = w_accept;
        w_tok[0].tick      = i_mode;
        w_tok[0].found     = 1'b0;
        w_tok[0].vic_valid = 1'b1;
        w_vage[0]          = '0;
        w_vidx[0]          = '0;
    end

    // row of entry cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lrc_cell #(
            .ADDR_BITS (ADDR_BITS),
            .AGE_BITS  (AGE_BITS),
            .IDX_W     (IDX_W),
            .IDX       (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_addr     (w_addr_bus),
            .i_tok      (w_tok[g]),
            .i_vic_age  (w_vage[g]),
            .i_vic_idx  (w_vidx[g]),
            .o_tok      (w_tok[g+1]),
            .o_vic_age  (w_vage[g+1]),
            .o_vic_idx  (w_vidx[g+1]),
            .i_ins_en   (w_pop),
            .i_ins_idx  (r_vic_idx),
            .i_ins_addr (w_rd_data)
        );
    end

    // pending fills
    lrc_fill_queue #(
        .FILL_DEPTH (FILL_DEPTH),
        .ADDR_BITS  (ADDR_BITS),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W)
    ) u_fill_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_offset (w_rd_offset),
        .o_rd_data   (w_rd_data),
        .i_push      (w_push),
        .i_push_data (r_addr),
        .i_pop       (w_pop),
        .o_count     (w_count)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_qi        <= '0;
            r_pend      <= 1'b0;
            r_tick      <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tick  <= i_mode;
                        r_addr  <= w_addr_in;
                        r_found <= 1'b0;
                        r_state <= S_CHAIN;
                    end
                end
                S_CHAIN: begin
                    // token leaves the last cell
                    if (w_tok[ENTRIES].active) begin
                        r_found   <= w_tok[ENTRIES].found;
                        r_vic_idx <= w_vidx[ENTRIES];
                        r_qi      <= '0;
                        r_pend    <= 1'b0;
                        r_state   <= r_tick ? S_FINISH : S_QSCAN;
                    end
                end
                S_QSCAN: begin
                    // one read issued and one compared per cycle
                    if (r_pend && (w_rd_data == r_addr)) begin
                        r_found <= 1'b1;
                    end
                    if (r_qi != w_count) begin
                        r_qi   <= r_qi + CNT_W'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_commit) begin
                        r_out_valid <= 1'b1;
                        r_hit       <= !r_tick && r_found;
                        r_ovf       <= !r_tick && !r_found && w_q_full;
                        r_inst      <= r_tick && w_q_nonempty;
                        r_inst_addr <= (r_tick && w_q_nonempty) ?
                                       w_rd_ext[OUT_ADDR_BITS-1:0] : '0;
                        r_vic_out   <= (r_tick && w_q_nonempty) ?
                                       w_vic_ext[OUT_IDX_BITS-1:0] : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall             = (r_state != S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_hit               = r_hit;
    assign o_fill_overflow     = r_ovf;
    assign o_installed         = r_inst;
    assign o_installed_address = r_inst_addr;
    assign o_victim_index      = r_vic_out;

endmodule

// File: design/lrc_cell.sv
// ----------------------------------------------------------------------------
// lrc_cell
// One cache entry: valid bit, address and age. Processes the search token
// as it passes and hands it, registered, to the next cell.
// ----------------------------------------------------------------------------
module lrc_cell
    import lrc_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int AGE_BITS  = DEF_AGE_BITS,
    parameter int IDX_W     = 4,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // shared lookup address
    input  logic [ADDR_BITS-1:0] i_addr,
    // token from the left neighbor
    input  t_tok_ctl             i_tok,
    input  logic [AGE_BITS-1:0]  i_vic_age,
    input  logic [IDX_W-1:0]     i_vic_idx,
    // token to the right neighbor
    output t_tok_ctl             o_tok,
    output logic [AGE_BITS-1:0]  o_vic_age,
    output logic [IDX_W-1:0]     o_vic_idx,
    // install broadcast
    input  logic                 i_ins_en,
    input  logic [IDX_W-1:0]     i_ins_idx,
    input  logic [ADDR_BITS-1:0] i_ins_addr
);

    localparam logic [IDX_W-1:0]    MY_IDX  = IDX_W'(IDX);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic                 r_valid, n_valid;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [AGE_BITS-1:0]  r_age, n_age;
    t_tok_ctl             r_tok, n_tok;
    logic [AGE_BITS-1:0]  r_vic_age, n_vic_age;
    logic [IDX_W-1:0]     r_vic_idx, n_vic_idx;

    logic [AGE_BITS-1:0]  w_aged;
    logic                 w_match;
    logic                 w_take;

    // saturating age after one tick
    assign w_aged = (r_age == AGE_MAX) ? r_age : r_age + AGE_BITS'(1);

    // first matching valid entry on a lookup
    assign w_match = r_valid && (r_addr == i_addr) && !i_tok.found;

    // victim: first invalid entry, else strictly older than the candidate
    assign w_take = i_tok.vic_valid && (!r_valid || (w_aged > i_vic_age));

    // entry update and token pass-through
    always_comb begin
        n_valid   = r_valid;
        n_addr    = r_addr;
        n_age     = r_age;
        n_tok     = i_tok;
        n_vic_age = i_vic_age;
        n_vic_idx = i_vic_idx;

        if (i_tok.active) begin
            if (i_tok.tick) begin
                n_age = w_aged;
                if (w_take) begin
                    n_vic_idx     = MY_IDX;
                    n_vic_age     = w_aged;
                    n_tok.vic_valid = r_valid;
                end
            end else if (w_match) begin
                n_age     = '0;
                n_tok.found = 1'b1;
            end
        end

        // install of a queued fill into this entry
        if (i_ins_en && (i_ins_idx == MY_IDX)) begin
            n_valid = 1'b1;
            n_addr  = i_ins_addr;
            n_age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
            r_tok   <= n_tok;
        end
        r_addr    <= n_addr;
        r_vic_age <= n_vic_age;
        r_vic_idx <= n_vic_idx;
    end

    assign o_tok     = r_tok;
    assign o_vic_age = r_vic_age;
    assign o_vic_idx = r_vic_idx;

endmodule

// File: design/lrc_fill_queue.sv
// ----------------------------------------------------------------------------
// lrc_fill_queue
// Ring buffer of pending fill addresses with one registered read port
// addressed relative to the head.
// ----------------------------------------------------------------------------
module lrc_fill_queue #(
    parameter int FILL_DEPTH = 16,
    parameter int ADDR_BITS  = 32,
    parameter int PTR_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PTR_W-1:0]     i_rd_offset,
    output logic [ADDR_BITS-1:0] o_rd_data,
    input  logic                 i_push,
    input  logic [ADDR_BITS-1:0] i_push_data,
    input  logic                 i_pop,
    output logic [CNT_W-1:0]     o_count
);

    localparam int               PTR_W1  = PTR_W + 1;
    localparam logic [PTR_W:0]   DEPTH_W = PTR_W1'(FILL_DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

    logic [ADDR_BITS-1:0] r_ring [FILL_DEPTH];
    logic [ADDR_BITS-1:0] r_rd_data;
    logic [PTR_W-1:0]     r_head;
    logic [CNT_W-1:0]     r_count;

    logic [PTR_W-1:0]     w_rd_slot;
    logic [PTR_W-1:0]     w_wr_slot;
    logic [PTR_W-1:0]     w_head_next;

    // (a + b) mod depth for a, b below depth
    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[PTR_W-1:0];
    endfunction

    assign w_rd_slot   = f_wrap(r_head, i_rd_offset);
    assign w_wr_slot   = f_wrap(r_head, r_count[PTR_W-1:0]);
    assign w_head_next = f_wrap(r_head, PTR_ONE);

    // storage: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ring[w_wr_slot] <= i_push_data;
        end
        r_rd_data <= r_ring[w_rd_slot];
    end

    // head and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_pop) begin
            r_head  <= w_head_next;
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule
